/* design/dpac_pkg.sv */
// dpac_pkg: shared types, widths, codes and helpers of the bitmap pixel to ARGB8888 converter
// used by dib_pixel_to_argb_converter_top and dpac_checker; no dependencies
`default_nettype none

package dpac_pkg;

   localparam int DIM_W        = 13;
   localparam int ADDR_W       = 24;
   localparam int PIXEL_W      = 32;
   localparam int FMT_W        = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int REQ_TDATA_W  = PIXEL_W;
   localparam int RSP_TDATA_W  = ADDR_W + PIXEL_W;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [FMT_W-1:0] {
      FMT_BGR24   = 2'd0,
      FMT_XRGB555 = 2'd1,
      FMT_ARGB32  = 2'd2
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FORMAT = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_idx_type;

   // zero means one, anything above the limit means the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned max_v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > max_v) begin
         r = DIM_W'(max_v);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] area_m1(input logic [DIM_W-1:0] w,
                                                  input logic [DIM_W-1:0] h);
      logic [2*DIM_W-1:0] p;
      p = w * h;
      return p[ADDR_W-1:0] - ADDR_W'(1);
   endfunction

endpackage

`default_nettype wire

/* design/dib_pixel_to_argb_converter_top.sv */
// dib_pixel_to_argb_converter_top: bottom-up bitmap pixels to ARGB8888 with top-down addresses
// depends on dpac_pkg
//
// req_ channel takes one source pixel per transaction in source order (bottom row first).
// rsp_ channel gives one transaction per pixel: tdata holds the top-down address and the
// ARGB8888 word, tlast marks the last pixel of a frame.
// csr_ channel writes pixel format, frame width and frame height; it is always ready.
// a width or height write restarts the frame, a format write applies to the next pixel.
// an accepted pixel is registered and rsp valid follows in the cycle after; throughput is
// one pixel per cycle while the receiver does not stall, set by the single output register
// and its pass-through ready. when the receiver stalls the output register holds and
// req_tready follows rsp_tready, so no transaction is lost.
// reset clears the output valid and the row and column counters and loads 24-bit format,
// 640 x 480; no clearing pass is needed.
`default_nettype none

module dib_pixel_to_argb_converter_top #(
   parameter int unsigned MAX_WIDTH  = dpac_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = dpac_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [dpac_pkg::REQ_TDATA_W-1:0] req_tdata,   // [31:0] source_pixel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [dpac_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // [23:0] dest_address, [55:24] argb_pixel
   output logic                                  rsp_tlast,   // frame_end
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dpac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dpac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dpac_pkg::*;

   localparam logic [DIM_W-1:0]  RstEffW = clamp_dim(RST_WIDTH, MAX_WIDTH);
   localparam logic [DIM_W-1:0]  RstEffH = clamp_dim(RST_HEIGHT, MAX_HEIGHT);
   localparam logic [ADDR_W-1:0] RstArea = area_m1(RstEffW, RstEffH);

   fmt_type            fmt_ff, fmt_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [ADDR_W-1:0]  area_ff, area_in;
   logic [DIM_W-1:0]   col_ff, row_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [PIXEL_W-1:0] argb_ff, argb_in;
   logic               last_ff, last_in;

   logic               csr_write;
   logic               restart;
   logic               accept;
   logic               last_col;
   logic               last_row;
   logic [PIXEL_W-1:0] px;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign px         = req_tdata;

   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_FORMAT: fmt_in = fmt_type'(csr_wdata[FMT_W-1:0]);
            REG_WIDTH: begin
               width_in = clamp_dim(csr_wdata, MAX_WIDTH);
               restart  = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, MAX_HEIGHT);
               restart   = 1'b1;
            end
            default: ;
         endcase
      end
      area_in = area_m1(width_in, height_in);
   end

   always_comb begin
      case (fmt_ff)
         FMT_BGR24:   argb_in = {ALPHA_OPAQUE, px[23:0]};
         FMT_XRGB555: argb_in = {ALPHA_OPAQUE, px[14:10], 3'b000, px[9:5], 3'b000,
                                 px[4:0], 3'b000};
         default:     argb_in = {ALPHA_OPAQUE, px[23:0]} | px;
      endcase
      addr_in  = base_ff - (ADDR_W'(width_ff) - ADDR_W'(1)) + ADDR_W'(col_ff);
      last_col = ({1'b0, col_ff} + (DIM_W+1)'(1)) >= {1'b0, width_ff};
      last_row = ({1'b0, row_ff} + (DIM_W+1)'(1)) >= {1'b0, height_ff};
      last_in  = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_BGR24;
         width_ff     <= RstEffW;
         height_ff    <= RstEffH;
         area_ff      <= RstArea;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= RstArea;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         if (restart) begin
            area_ff <= area_in;
            col_ff  <= '0;
            row_ff  <= '0;
            base_ff <= area_in;
         end else if (accept) begin
            if (last_col && last_row) begin
               col_ff  <= '0;
               row_ff  <= '0;
               base_ff <= area_ff;
            end else if (last_col) begin
               col_ff  <= '0;
               row_ff  <= row_ff + DIM_W'(1);
               base_ff <= base_ff - ADDR_W'(width_ff);
            end else begin
               col_ff <= col_ff + DIM_W'(1);
            end
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= addr_in;
         argb_ff <= argb_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {argb_ff, addr_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

/* design/dpac_checker.sv */
// dpac_checker: port-level assertions for dib_pixel_to_argb_converter_top, bound to the top level
// depends on dpac_pkg
`default_nettype none

module dpac_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [dpac_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);
   import dpac_pkg::*;

   // stalled output transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // every accepted pixel shows up on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted pixel not presented one cycle later");

   // empty output register never blocks the input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1 -: 8] == ALPHA_OPAQUE)
      else $error("alpha not forced opaque");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind dib_pixel_to_argb_converter_top dpac_checker u_dpac_checker (.*);

`default_nettype wire

/* tb/tb_dib_pixel_to_argb_converter_top.sv */
// testbench for dib_pixel_to_argb_converter_top: directed and random pixel streams checked
// against an in-bench model of the format conversion and bottom-up to top-down addressing
// depends on dpac_pkg and dib_pixel_to_argb_converter_top
`timescale 1ns / 1ps

module tb_dib_pixel_to_argb_converter_top;
   import dpac_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [FMT_W-1:0]     FMT_UNUSED = 2'd3;
   localparam int                   WATCHDOG_LIMIT = 2000;
   localparam int                   RANDOM_PIXELS  = 600;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] argb;
      logic               frame_end;
   } argb_result_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [PIXEL_W-1:0] pending_pixels[$];
   argb_result_type    expected_argb[$];
   reg_write_type      reg_writes[$];
   reg_write_type      next_write;

   // model state
   logic [FMT_W-1:0] cfg_format;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   int unsigned      col_pos;
   int unsigned      src_row;
   int unsigned      row_last_addr;

   int error_count = 0;
   int req_idle_pct = 29;
   int rsp_stall_pct = 29;
   int quiet_cycles;

   dib_pixel_to_argb_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned usable_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned lim);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > lim) begin
         return lim;
      end
      return 32'(v);
   endfunction

   task automatic restart_frame_count();
      col_pos = 0;
      src_row = 0;
      row_last_addr = usable_dim(cfg_width, DEF_MAX_WIDTH) *
                      usable_dim(cfg_height, DEF_MAX_HEIGHT) - 1;
   endtask

   task automatic apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_FORMAT: begin
            cfg_format = data[FMT_W-1:0];
         end
         REG_WIDTH: begin
            cfg_width = data;
            restart_frame_count();
         end
         REG_HEIGHT: begin
            cfg_height = data;
            restart_frame_count();
         end
         default: begin
         end
      endcase
   endtask

   task automatic convert_and_advance(input logic [PIXEL_W-1:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     addr;
      logic            last_col;
      logic            last_row;
      argb_result_type res;
      w = usable_dim(cfg_width, DEF_MAX_WIDTH);
      h = usable_dim(cfg_height, DEF_MAX_HEIGHT);
      case (cfg_format)
         FMT_XRGB555: begin
            res.argb = {ALPHA_OPAQUE, px[14:10], 3'b000, px[9:5], 3'b000, px[4:0], 3'b000};
         end
         // 24-bit keeps the low three bytes; pass-through gets alpha forced over its top byte
         default: begin
            res.argb = {ALPHA_OPAQUE, px[23:0]};
         end
      endcase
      addr = row_last_addr - (w - 1) + col_pos;
      last_col = (col_pos + 1 >= w);
      last_row = (src_row + 1 >= h);
      res.addr = addr[ADDR_W-1:0];
      res.frame_end = last_col && last_row;
      expected_argb = {expected_argb, res};
      if (last_col) begin
         if (last_row) begin
            restart_frame_count();
         end else begin
            col_pos = 0;
            src_row = src_row + 1;
            row_last_addr = row_last_addr - w;
         end
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_result(input logic [RSP_TDATA_W-1:0] data, input logic last);
      argb_result_type exp_res;
      if (expected_argb.size() == 0) begin
         flag_error($sformatf("unexpected transaction tdata=%h tlast=%b", data, last));
      end else begin
         exp_res = expected_argb.pop_front();
         if (data[ADDR_W-1:0] !== exp_res.addr) begin
            flag_error($sformatf("dest_address %h, expected %h", data[ADDR_W-1:0], exp_res.addr));
         end
         if (data[ADDR_W +: PIXEL_W] !== exp_res.argb) begin
            flag_error($sformatf("argb_pixel %h, expected %h",
                                 data[ADDR_W +: PIXEL_W], exp_res.argb));
         end
         if (last !== exp_res.frame_end) begin
            flag_error($sformatf("frame_end %b, expected %b at address %h",
                                 last, exp_res.frame_end, exp_res.addr));
         end
      end
   endtask

   // driver for the pixel and register channels, model updated on each transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         cfg_format = FMT_BGR24;
         cfg_width = RST_WIDTH;
         cfg_height = RST_HEIGHT;
         restart_frame_count();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg_write(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            convert_and_advance(req_tdata);
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes.size() != 0) begin
               next_write = reg_writes.pop_front();
               csr_index <= next_write.idx;
               csr_wdata <= next_write.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_tdata <= pending_pixels.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata, rsp_tlast);
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles with no transaction on any channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("dib_pixel_to_argb_converter_top verification failed");
      $finish;
   end

   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || expected_argb.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      reg_write_type w;
      w.idx = idx;
      w.data = value[CSR_DATA_W-1:0];
      reg_writes = {reg_writes, w};
      do begin
         @(posedge clock);
      end while (reg_writes.size() != 0 || csr_valid);
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] px);
      pending_pixels = {pending_pixels, px};
   endtask

   task automatic queue_random_pixels(input int n);
      repeat (n) queue_pixel($urandom());
   endtask

   initial begin
      int sent;
      int phase;
      int n;
      int unsigned w;
      int unsigned h;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: first pixels land on the last destination row
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hA512_3456);
      wait_drained();

      // zero sizes act as 1 x 1, every pixel ends a frame
      write_reg(REG_FORMAT, FMT_XRGB555);
      write_reg(REG_WIDTH, 0);
      write_reg(REG_HEIGHT, 0);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h0000_7FFF);
      queue_pixel(32'hFFFF_8000);
      queue_pixel(32'h0000_5AD6);
      wait_drained();

      // unused format code, then format change mid-frame
      write_reg(REG_FORMAT, FMT_UNUSED);
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 2);
      queue_random_pixels(3);
      wait_drained();
      write_reg(REG_FORMAT, FMT_ARGB32);
      queue_random_pixels(3);
      wait_drained();

      // unknown register index leaves the frame running
      write_reg(REG_UNUSED, 13'h1FFF);
      queue_random_pixels(2);
      wait_drained();

      // sizes above the limit and at the limit
      write_reg(REG_WIDTH, 13'h1FFF);
      write_reg(REG_HEIGHT, 13'h1FFF);
      queue_random_pixels(2);
      wait_drained();
      write_reg(REG_WIDTH, DEF_MAX_WIDTH);
      write_reg(REG_HEIGHT, DEF_MAX_HEIGHT + 1);
      queue_random_pixels(2);
      wait_drained();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         req_idle_pct = (phase == 2) ? 0 : 29;
         rsp_stall_pct = (phase == 2) ? 0 : 29;
         write_reg(REG_FORMAT, $urandom_range(0, 3));
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               w = $urandom_range(0, 8191);
               h = $urandom_range(0, 8191);
            end else begin
               w = $urandom_range(1, 12);
               h = $urandom_range(1, 6);
            end
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
         end
         n = (phase == 2) ? 150 : $urandom_range(1, 60);
         queue_random_pixels(n);
         sent += n;
         phase++;
         wait_drained();
      end
      req_idle_pct = 29;
      rsp_stall_pct = 29;

      if (error_count == 0) begin
         $display("dib_pixel_to_argb_converter_top verification clean");
      end else begin
         $display("dib_pixel_to_argb_converter_top verification failed");
      end
      $finish;
   end

endmodule

/* dib_pixel_to_argb_converter_top.f */
design/dpac_pkg.sv
design/dib_pixel_to_argb_converter_top.sv
design/dpac_checker.sv
tb/tb_dib_pixel_to_argb_converter_top.sv
